@@ rtl/adsr_envelope_generator_assert.svh @@
// Assertion macros used by the envelope generator checker.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ADSR_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("envelope generator check failed");

// Consequent must hold in the cycle after the antecedent.
`define ADSR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("envelope generator check failed");

`endif

@@ rtl/adsr_pkg.sv @@
// Package with the types, constants and codes of the envelope generator.
package adsr_pkg;

   localparam int LEVEL_FRAC_BITS = 19;
   localparam int LEVEL_W         = LEVEL_FRAC_BITS + 5;
   localparam int GAIN_BITS       = 16;
   localparam int FACTOR_W        = 24;
   localparam int FACTOR_FRAC     = 22;
   localparam int OUT_W           = 24;
   localparam int OUT_FRAC        = 17;
   localparam int OUT_SHIFT       = LEVEL_FRAC_BITS + GAIN_BITS - 2 - OUT_FRAC;
   localparam int MUL_W           = (LEVEL_W > FACTOR_W) ? LEVEL_W : FACTOR_W;
   localparam int PROD_W          = 2 * MUL_W;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 24;

   localparam logic [LEVEL_W-1:0]   LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;
   localparam logic [LEVEL_W-1:0]   LEVEL_MAX = '1;
   localparam logic [OUT_W-1:0]     OUT_MAX   = '1;
   localparam logic [GAIN_BITS-1:0] GAIN_STEP =
      GAIN_BITS'(((1 << (GAIN_BITS - 2)) + 50) / 100);

   localparam logic [CSR_ADDR_W-1:0] CSR_ATTACK_RATE     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDITIVE_ATTACK = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY_FACTOR    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SUSTAIN_LEVEL   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE_FACTOR  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_PEAK_LEVEL      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_REZERO          = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_CONDITIONAL     = 3'd7;

   typedef enum logic [2:0] {
      PH_ATTACK  = 3'd0,
      PH_DECAY   = 3'd1,
      PH_SUSTAIN = 3'd2,
      PH_RELEASE = 3'd3,
      PH_DONE    = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_LVL,
      ST_ENV
   } state_type;

   typedef enum logic [1:0] {
      EV_STAY,
      EV_MUL,
      EV_ENV
   } eval_type;

   typedef struct packed {
      logic                 key_on;
      logic                 key_off;
      logic                 retrigger;
      logic [GAIN_BITS-1:0] target_gain;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] envelope;
      logic             finished;
      logic [2:0]       phase;
   } rsp_type;

   typedef struct packed {
      logic [23:0] attack_rate;
      logic        additive_attack;
      logic [22:0] decay_factor;
      logic [23:0] sustain_level;
      logic [22:0] release_factor;
      logic [23:0] peak_level;
      logic        rezero;
      logic        conditional;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic eval;
      logic mul;
      logic lvl;
      logic emit;
   } cmd_type;

   typedef struct packed {
      eval_type eval;
      logic     out_free;
   } sts_type;

endpackage

@@ rtl/adsr_csr.sv @@
// Configuration registers of the envelope generator.
module adsr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [adsr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [adsr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output adsr_pkg::cfg_type                cfg
);
   import adsr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_ATTACK_RATE:     cfg_in.attack_rate     = csr_wdata[23:0];
            CSR_ADDITIVE_ATTACK: cfg_in.additive_attack = csr_wdata[0];
            CSR_DECAY_FACTOR:    cfg_in.decay_factor    = csr_wdata[22:0];
            CSR_SUSTAIN_LEVEL:   cfg_in.sustain_level   = csr_wdata[23:0];
            CSR_RELEASE_FACTOR:  cfg_in.release_factor  = csr_wdata[22:0];
            CSR_PEAK_LEVEL:      cfg_in.peak_level      = csr_wdata[23:0];
            CSR_REZERO:          cfg_in.rezero          = csr_wdata[0];
            CSR_CONDITIONAL:     cfg_in.conditional     = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_rate     <= 24'd4236247;
         cfg_ff.additive_attack <= 1'b0;
         cfg_ff.decay_factor    <= 23'd4152361;
         cfg_ff.sustain_level   <= 24'd524288;
         cfg_ff.release_factor  <= 23'd4152361;
         cfg_ff.peak_level      <= 24'd6291456;
         cfg_ff.rezero          <= 1'b0;
         cfg_ff.conditional     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/adsr_ctrl.sv @@
// Sequencing state machine of the envelope generator.
module adsr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  adsr_pkg::sts_type sts,
   output adsr_pkg::cmd_type cmd
);
   import adsr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            case (sts.eval)
               EV_MUL:  state_in = ST_MUL;
               EV_ENV:  state_in = ST_ENV;
               default: state_in = ST_EVAL;
            endcase
         end
         ST_MUL: state_in = ST_LVL;
         ST_LVL: state_in = ST_ENV;
         ST_ENV: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd.accept = (state_ff == ST_IDLE) && req_valid;
      cmd.eval   = (state_ff == ST_EVAL);
      cmd.mul    = (state_ff == ST_MUL);
      cmd.lvl    = (state_ff == ST_LVL);
      cmd.emit   = (state_ff == ST_ENV) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/adsr_dp.sv @@
// Datapath of the envelope generator: level, gain, shared multiplier and output register.
module adsr_dp (
   input  logic              clock,
   input  logic              reset,
   input  adsr_pkg::cfg_type cfg,
   input  adsr_pkg::cmd_type cmd,
   output adsr_pkg::sts_type sts,
   input  adsr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output adsr_pkg::rsp_type rsp_data
);
   import adsr_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [GAIN_BITS-1:0] smooth_ff, smooth_in;
   logic [GAIN_BITS-1:0] target_ff, target_in;
   logic                 up_ff, up_in;
   logic                 dn_ff, dn_in;
   logic                 pend_ff, pend_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   phase_type            acc_phase;
   logic                 acc_pend;
   logic [LEVEL_W-1:0]   acc_level;
   phase_type            post_phase;
   logic [MUL_W-1:0]     mul_a, mul_b, factor;
   logic [PROD_W-1:0]    mul_p;
   logic [LEVEL_W-1:0]   lvl_scaled;
   logic [LEVEL_W:0]     lin_sum;
   logic [LEVEL_W-1:0]   lin_level;
   logic [OUT_W-1:0]     env_val;
   logic                 env_zero;
   logic [GAIN_BITS:0]   up_sum;
   logic [GAIN_BITS-1:0] dn_diff;
   logic [GAIN_BITS-1:0] glide_val;

   // Events of the accepted word, applied in order: key-off, pending release, triggers.
   always_comb begin
      acc_phase = phase_ff;
      acc_pend  = pend_ff;
      acc_level = level_ff;
      if (req_data.key_off) begin
         acc_pend = 1'b1;
         if (!cfg.conditional || phase_ff != PH_ATTACK) begin
            acc_phase = PH_RELEASE;
         end
      end
      if (acc_pend && cfg.conditional && acc_phase != PH_ATTACK) begin
         acc_phase = PH_RELEASE;
      end
      if (req_data.key_on && (cfg.rezero || level_ff < LEVEL_ONE)) begin
         acc_level = LEVEL_ONE;
      end
      if (req_data.key_on || req_data.retrigger) begin
         if (cfg.rezero) begin
            acc_level = LEVEL_ONE;
         end
         acc_phase = PH_ATTACK;
         acc_pend  = 1'b0;
      end
   end

   always_comb begin
      case (phase_ff)
         PH_RELEASE: factor = MUL_W'(cfg.release_factor);
         PH_ATTACK:  factor = MUL_W'(cfg.attack_rate);
         default:    factor = MUL_W'(cfg.decay_factor);
      endcase
      if (cmd.mul) begin
         mul_a = MUL_W'(level_ff);
         mul_b = factor;
      end else begin
         mul_a = MUL_W'(level_ff - LEVEL_ONE);
         mul_b = MUL_W'(smooth_ff);
      end
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      if (|prod_ff[PROD_W-1:FACTOR_FRAC+LEVEL_W]) begin
         lvl_scaled = LEVEL_MAX;
      end else begin
         lvl_scaled = prod_ff[FACTOR_FRAC +: LEVEL_W];
      end
      lin_sum = {1'b0, level_ff} + (LEVEL_W + 1)'(cfg.attack_rate);
      lin_level = lin_sum[LEVEL_W] ? LEVEL_MAX : lin_sum[LEVEL_W-1:0];
      env_zero = (phase_ff == PH_DONE) || (level_ff <= LEVEL_ONE) || (smooth_ff == '0);
      if (env_zero) begin
         env_val = '0;
      end else if (|mul_p[PROD_W-1:OUT_SHIFT+OUT_W]) begin
         env_val = OUT_MAX;
      end else begin
         env_val = mul_p[OUT_SHIFT +: OUT_W];
      end
   end

   always_comb begin
      up_sum  = {1'b0, smooth_ff} + (GAIN_BITS + 1)'(GAIN_STEP);
      dn_diff = smooth_ff - GAIN_STEP;
      glide_val = smooth_ff;
      if (up_ff) begin
         glide_val = (up_sum > {1'b0, target_ff}) ? target_ff : up_sum[GAIN_BITS-1:0];
      end else if (dn_ff) begin
         glide_val = (smooth_ff < GAIN_STEP || dn_diff < target_ff) ? target_ff : dn_diff;
      end
   end

   always_comb begin
      post_phase = phase_ff;
      case (phase_ff)
         PH_RELEASE: begin
            if (level_ff <= LEVEL_ONE) begin
               post_phase = PH_DONE;
            end
         end
         PH_ATTACK: begin
            if (level_ff >= cfg.peak_level) begin
               post_phase = PH_DECAY;
            end
         end
         PH_DECAY: begin
            if (level_ff <= cfg.sustain_level) begin
               post_phase = PH_SUSTAIN;
            end
         end
         default: post_phase = phase_ff;
      endcase
   end

   always_comb begin
      case (phase_ff)
         PH_RELEASE: sts.eval = (level_ff > LEVEL_ONE) ? EV_MUL : EV_STAY;
         PH_ATTACK: begin
            if (level_ff < cfg.peak_level) begin
               sts.eval = cfg.additive_attack ? EV_ENV : EV_MUL;
            end else begin
               sts.eval = EV_STAY;
            end
         end
         PH_DECAY:   sts.eval = (level_ff > cfg.sustain_level) ? EV_MUL : EV_STAY;
         PH_SUSTAIN: sts.eval = EV_ENV;
         default:    sts.eval = EV_ENV;
      endcase
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      phase_in     = phase_ff;
      level_in     = level_ff;
      smooth_in    = smooth_ff;
      target_in    = target_ff;
      up_in        = up_ff;
      dn_in        = dn_ff;
      pend_in      = pend_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.accept) begin
         phase_in  = acc_phase;
         pend_in   = acc_pend;
         level_in  = acc_level;
         target_in = req_data.target_gain;
         up_in     = smooth_ff < req_data.target_gain;
         dn_in     = smooth_ff > req_data.target_gain;
      end

      if (cmd.eval) begin
         case (phase_ff)
            PH_RELEASE: begin
               if (level_ff <= LEVEL_ONE) begin
                  level_in = LEVEL_ONE;
                  phase_in = PH_DONE;
                  pend_in  = 1'b0;
               end
            end
            PH_ATTACK: begin
               if (level_ff < cfg.peak_level) begin
                  if (cfg.additive_attack) begin
                     level_in = lin_level;
                  end
               end else begin
                  phase_in = PH_DECAY;
               end
            end
            PH_DECAY: begin
               if (level_ff <= cfg.sustain_level) begin
                  phase_in = PH_SUSTAIN;
               end
            end
            PH_SUSTAIN: level_in = cfg.sustain_level;
            default:    phase_in = PH_DONE;
         endcase
      end

      if (cmd.mul) begin
         prod_in = mul_p;
      end

      if (cmd.lvl) begin
         level_in = lvl_scaled;
      end

      if (cmd.emit) begin
         phase_in = post_phase;
         if (phase_ff == PH_RELEASE && post_phase == PH_DONE) begin
            level_in = LEVEL_ONE;
            pend_in  = 1'b0;
         end
         if (phase_ff != PH_DONE) begin
            smooth_in = glide_val;
         end
         rsp_in.envelope = env_val;
         rsp_in.finished = (post_phase == PH_DONE);
         rsp_in.phase    = post_phase;
         rsp_valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         level_ff     <= LEVEL_ONE;
         smooth_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         smooth_ff    <= smooth_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      up_ff     <= up_in;
      dn_ff     <= dn_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/adsr_envelope_generator.sv @@
// ADSR envelope generator top level. One word per audio sample goes in and one
// envelope word comes out. The events of a word are applied in the accepting cycle,
// then the word is evaluated once for each phase that the tick passes through without
// output, and the multiplicative attack, decay and release form the level product on
// the single shared 24 by 24 bit multiplier and register it (MUL, then LVL); the same
// multiplier then forms the gain-scaled output in the last state (ENV). Words are
// worked on one at a time; the next word is taken in the cycle after a result enters
// the output register, which holds it until the consumer takes it. Configuration
// registers may be written only while no word is in flight.
module adsr_envelope_generator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  adsr_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output adsr_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [adsr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [adsr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import adsr_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   adsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   adsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   adsr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/adsr_checker.sv @@
// Port-level checker of the envelope generator and its bind statement.
`include "adsr_envelope_generator_assert.svh"

module adsr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input adsr_pkg::rsp_type rsp_data
);

   // A held result keeps its value until it is taken.
   `ADSR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Only one word is in flight, so acceptance closes the input.
   `ADSR_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

   // A new result is only written while a word is being worked on.
   `ADSR_ASSERT_SAME(a_rsp_from_work, rsp_valid && !$past(rsp_valid), !$past(req_ready))

   // A finished envelope has reached the bottom and outputs zero.
   `ADSR_ASSERT_SAME(a_done_is_zero, rsp_valid && rsp_data.finished, rsp_data.envelope == '0)

endmodule

bind adsr_envelope_generator adsr_checker u_checker (.*);

@@ tb/tb_adsr_envelope_generator.sv @@
// Self-checking testbench for the ADSR envelope generator, with a built-in envelope predictor.
`timescale 1ns / 100ps

module tb_adsr_envelope_generator;
   import adsr_pkg::*;

   typedef longint unsigned u64;

   localparam u64     LVL_ONE = u64'(LEVEL_ONE);
   localparam u64     LVL_TOP = u64'(LEVEL_MAX);
   localparam u64     ENV_TOP = u64'(OUT_MAX);
   localparam longint GSTEP   = longint'(GAIN_STEP);

   class envelope_tracker;
      cfg_type   regs;
      phase_type cur_phase;
      u64        lvl;
      longint    gain_now;
      bit        rel_wait;
      rsp_type   pending_env[$];
      int        errors;

      function new();
         regs.attack_rate     = 24'd4236247;
         regs.additive_attack = 1'b0;
         regs.decay_factor    = 23'd4152361;
         regs.sustain_level   = 24'd524288;
         regs.release_factor  = 23'd4152361;
         regs.peak_level      = 24'd6291456;
         regs.rezero          = 1'b0;
         regs.conditional     = 1'b0;
         cur_phase = PH_DONE;
         lvl       = LVL_ONE;
         gain_now  = 0;
         rel_wait  = 0;
         errors    = 0;
      endfunction

      function void set_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         case (addr)
            CSR_ATTACK_RATE:     regs.attack_rate     = data;
            CSR_ADDITIVE_ATTACK: regs.additive_attack = data[0];
            CSR_DECAY_FACTOR:    regs.decay_factor    = data[22:0];
            CSR_SUSTAIN_LEVEL:   regs.sustain_level   = data;
            CSR_RELEASE_FACTOR:  regs.release_factor  = data[22:0];
            CSR_PEAK_LEVEL:      regs.peak_level      = data;
            CSR_REZERO:          regs.rezero          = data[0];
            CSR_CONDITIONAL:     regs.conditional     = data[0];
            default: ;
         endcase
      endfunction

      function u64 mul_level(u64 lv, u64 f);
         u64 p;
         p = (lv * f) >> FACTOR_FRAC;
         return (p > LVL_TOP) ? LVL_TOP : p;
      endfunction

      function u64 gain_scaled();
         longint d;
         longint p;
         d = longint'(lvl) - longint'(LVL_ONE);
         if (d <= 0 || gain_now <= 0) return 0;
         p = (d * gain_now) >>> OUT_SHIFT;
         return (u64'(p) > ENV_TOP) ? ENV_TOP : u64'(p);
      endfunction

      function void step_gain(int dir, longint tgt);
         if (dir > 0) begin
            gain_now = gain_now + GSTEP;
            if (gain_now > tgt) gain_now = tgt;
         end else if (dir == 0) begin
            gain_now = gain_now - GSTEP;
            if (gain_now < tgt) gain_now = tgt;
         end
      endfunction

      function rsp_type advance_envelope(req_type w);
         longint  tgt;
         int      dir;
         u64      env;
         bit      sample_out;
         rsp_type r;
         tgt = longint'(w.target_gain);
         dir = -1;
         env = 0;
         sample_out = 0;
         if (gain_now < tgt) dir = 1;
         else if (gain_now > tgt) dir = 0;
         if (w.key_off) begin
            rel_wait = 1;
            if (!regs.conditional || cur_phase != PH_ATTACK) cur_phase = PH_RELEASE;
         end
         if (rel_wait && regs.conditional && cur_phase != PH_ATTACK) cur_phase = PH_RELEASE;
         if (w.key_on && (regs.rezero || lvl < LVL_ONE)) lvl = LVL_ONE;
         if (w.key_on || w.retrigger) begin
            if (regs.rezero) lvl = LVL_ONE;
            cur_phase = PH_ATTACK;
            rel_wait = 0;
         end
         while (!sample_out) begin
            case (cur_phase)
               PH_RELEASE: begin
                  if (lvl > LVL_ONE) begin
                     lvl = mul_level(lvl, u64'(regs.release_factor));
                     env = gain_scaled();
                     step_gain(dir, tgt);
                     sample_out = 1;
                  end
                  if (lvl <= LVL_ONE) begin
                     lvl = LVL_ONE;
                     cur_phase = PH_DONE;
                     rel_wait = 0;
                  end
               end
               PH_ATTACK: begin
                  if (lvl < u64'(regs.peak_level)) begin
                     if (regs.additive_attack) begin
                        lvl = lvl + u64'(regs.attack_rate);
                        if (lvl > LVL_TOP) lvl = LVL_TOP;
                     end else begin
                        lvl = mul_level(lvl, u64'(regs.attack_rate));
                     end
                     env = gain_scaled();
                     step_gain(dir, tgt);
                     sample_out = 1;
                  end
                  if (lvl >= u64'(regs.peak_level)) cur_phase = PH_DECAY;
               end
               PH_DECAY: begin
                  if (lvl > u64'(regs.sustain_level)) begin
                     lvl = mul_level(lvl, u64'(regs.decay_factor));
                     env = gain_scaled();
                     step_gain(dir, tgt);
                     sample_out = 1;
                  end
                  if (lvl <= u64'(regs.sustain_level)) cur_phase = PH_SUSTAIN;
               end
               PH_SUSTAIN: begin
                  lvl = u64'(regs.sustain_level);
                  env = gain_scaled();
                  step_gain(dir, tgt);
                  sample_out = 1;
               end
               default: begin
                  cur_phase = PH_DONE;
                  env = 0;
                  sample_out = 1;
               end
            endcase
         end
         r.envelope = env[OUT_W-1:0];
         r.finished = (cur_phase == PH_DONE);
         r.phase    = cur_phase;
         return r;
      endfunction

      function void note_word(req_type w);
         pending_env.push_back(advance_envelope(w));
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("%0t: mismatch: %s", $realtime, what);
      endfunction

      function void check_word(rsp_type got);
         rsp_type exp;
         if (pending_env.size() == 0) begin
            flag($sformatf("unexpected word envelope %0d phase %0d", got.envelope, got.phase));
            return;
         end
         exp = pending_env.pop_front();
         if (got.envelope !== exp.envelope)
            flag($sformatf("envelope expected %0d got %0d", exp.envelope, got.envelope));
         if (got.finished !== exp.finished)
            flag($sformatf("finished expected %0b got %0b", exp.finished, got.finished));
         if (got.phase !== exp.phase)
            flag($sformatf("phase expected %0d got %0d", exp.phase, got.phase));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   envelope_tracker tracker = new();
   bit              tx_calm = 0;
   bit              rx_calm = 0;
   int              stall_left = 0;

   adsr_envelope_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin : rx_side
      int r;
      r = $urandom_range(0, 99);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rx_calm || r < 70) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         stall_left <= (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 50);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_word(rsp_data);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tx_calm || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type mk(bit on, bit off, bit rt, logic [GAIN_BITS-1:0] g);
      req_type w;
      w.key_on      = on;
      w.key_off     = off;
      w.retrigger   = rt;
      w.target_gain = g;
      return w;
   endfunction

   task automatic send_word(req_type w);
      int gap;
      gap = pick_gap();
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      tracker.note_word(w);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.pending_env.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      tracker.set_reg(addr, data);
   endtask

   task automatic write_settings(int p);
      logic [23:0] ar, df, sl, rf, pk;
      logic        la, rz, cd;
      case (p)
         0: begin
            ar = 6291456; la = 0; df = 3355443; sl = 1048576;
            rf = 2936013; pk = 4194304; rz = 0; cd = 0;
         end
         1: begin
            ar = 65536; la = 1; df = 3774874; sl = 786432;
            rf = 3355443; pk = 2097152; rz = 1; cd = 1;
         end
         2: begin
            ar = 16777215; la = 0; df = 4194304; sl = 16777215;
            rf = 4194304; pk = 16777215; rz = 1; cd = 0;
         end
         3: begin
            ar = 0; la = 0; df = 0; sl = 524288;
            rf = 0; pk = 1048576; rz = 0; cd = 0;
         end
         4: begin
            ar = 0; la = 1; df = 4194304; sl = 524288;
            rf = 4194304; pk = 16777215; rz = 0; cd = 1;
         end
         5: begin
            ar = 16777215; la = 1; df = 0; sl = 524288;
            rf = 0; pk = 524288; rz = 1; cd = 1;
         end
         default: begin
            la = 1'($urandom_range(0, 1));
            rz = 1'($urandom_range(0, 1));
            cd = 1'($urandom_range(0, 1));
            if (p >= 10) begin
               ar = 24'($urandom_range(0, 16777215));
               df = 24'($urandom_range(0, 4194304));
               sl = 24'($urandom_range(524288, 16777215));
               rf = 24'($urandom_range(0, 4194304));
               pk = 24'($urandom_range(524288, 16777215));
            end else begin
               ar = la ? 24'($urandom_range(2000, 400000))
                       : 24'($urandom_range(4300000, 9000000));
               df = 24'($urandom_range(2500000, 4194304));
               sl = 24'($urandom_range(524288, 3000000));
               rf = 24'($urandom_range(2500000, 4194304));
               pk = 24'($urandom_range(524288, 8388608));
            end
         end
      endcase
      put_reg(CSR_ATTACK_RATE, ar);
      put_reg(CSR_ADDITIVE_ATTACK, CSR_DATA_W'(la));
      put_reg(CSR_DECAY_FACTOR, df);
      put_reg(CSR_SUSTAIN_LEVEL, sl);
      put_reg(CSR_RELEASE_FACTOR, rf);
      put_reg(CSR_PEAK_LEVEL, pk);
      put_reg(CSR_REZERO, CSR_DATA_W'(rz));
      put_reg(CSR_CONDITIONAL, CSR_DATA_W'(cd));
      csr_we <= 1'b0;
   endtask

   task automatic directed_words();
      send_word(mk(0, 0, 0, 16'hFFFF));
      send_word(mk(1, 0, 0, 16'hFFFF));
      send_word(mk(0, 0, 0, 16'hFFFF));
      wait_idle();
      write_settings(0);
      send_word(mk(0, 0, 0, 16'h0000));
      send_word(mk(1, 0, 0, 16'h4000));
      repeat (3) send_word(mk(0, 0, 0, 16'h4000));
      send_word(mk(0, 1, 0, 16'h4000));
      repeat (2) send_word(mk(0, 0, 0, 16'h4000));
      send_word(mk(1, 1, 0, 16'h8000));
      send_word(mk(0, 0, 1, 16'h8000));
      send_word(mk(0, 1, 1, 16'h0000));
      send_word(mk(0, 0, 0, 16'h0000));
      wait_idle();
      write_settings(1);
      send_word(mk(1, 0, 0, 16'hFFFF));
      send_word(mk(0, 1, 0, 16'hFFFF));
      repeat (3) send_word(mk(0, 0, 0, 16'hFFFF));
      send_word(mk(0, 0, 1, 16'h7FFF));
      send_word(mk(1, 1, 1, 16'hFFFF));
   endtask

   task automatic run_phase(int p, int count);
      int                   i;
      int                   r;
      bit                   note_on;
      logic [2:0]           ev;
      logic [GAIN_BITS-1:0] g;
      wait_idle();
      write_settings(p);
      tx_calm = (p % 4 == 3);
      rx_calm = (p % 4 == 3);
      note_on = 0;
      g = GAIN_BITS'($urandom);
      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         ev = 3'b000;
         if (r < 4) begin
            ev = 3'($urandom_range(0, 7));
         end else if (!note_on && r < 12) begin
            ev = 3'b100;
            note_on = 1;
         end else if (note_on && r < 10) begin
            ev = 3'b010;
            note_on = 0;
         end else if (note_on && r < 13) begin
            ev = 3'b001;
         end
         if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 3))
               0: g = '0;
               1: g = '1;
               2: g = g + GAIN_BITS'($urandom_range(0, 400)) - GAIN_BITS'(200);
               default: g = GAIN_BITS'($urandom);
            endcase
         end
         send_word(mk(ev[2], ev[1], ev[0], g));
         if (p == 1 && i == count / 2) wait_idle();
      end
   endtask

   initial begin : stimulus
      int p;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_words();
      for (p = 0; p < 12; p++) run_phase(p, 80);
      wait_idle();
      if (tracker.errors == 0 && tracker.pending_env.size() == 0)
         $display("adsr_envelope_generator test passed");
      else
         $display("adsr_envelope_generator test failed");
      $finish;
   end

   initial begin : watchdog
      #6_000_000;
      $display("adsr_envelope_generator test failed");
      $finish;
   end

endmodule
